### design/calendar_date_normalizer_macros.svh
// Assertion macros used by the calendar date normalizer datapath.
`ifndef CALENDAR_DATE_NORMALIZER_MACROS_SVH
`define CALENDAR_DATE_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS
`define CDN_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CDN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CDN_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CDN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/cdn_pkg.sv
// Types, constants and calendar tables for the calendar date normalizer.
package cdn_pkg;

  localparam int YEAR_IN_W  = 14;
  localparam int MONTH_IN_W = 13;
  localparam int DAY_IN_W   = 16;
  localparam int YEAR_W     = 15;
  localparam int MONTH_W    = 4;
  localparam int MDAY_W     = 5;
  localparam int YDAY_W     = 9;
  localparam int YDAY_ACC_W = 17;
  localparam int CYCLE_W    = 9;

  localparam int MONTHS = 12;

  // floor(x / 12) = (x * MON_RECIP) >> MON_SHIFT, exact for x <= 4097
  localparam logic [12:0] MON_RECIP = 13'd5462;
  localparam int          MON_SHIFT = 16;

  // year offset keeps the mod-400 operand positive
  localparam logic signed [15:0] YEAR_OFFSET = 16'sd8800;
  localparam logic [15:0]        YEAR_RECIP  = 16'd41944;
  localparam int                 YEAR_SHIFT  = 24;
  localparam int                 YEAR_CYCLE  = 400;

  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  typedef struct packed {
    logic load;
    logic fold_mul;
    logic fold_apply;
    logic leap_mul;
    logic leap_apply;
    logic day_init;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic out_busy;
  } stat_t;

  // leap rule from the year's position in the 400-year cycle
  function automatic logic leap_of(input logic [CYCLE_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [8:0] ndays_of(input logic [CYCLE_W-1:0] r);
    return leap_of(r) ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  // days before the first of month mon; mon 13 gives the year length
  function automatic logic [8:0] cum_days(input logic leap, input logic [MONTH_W-1:0] mon);
    logic [8:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      4'd13:   base = 9'd365;
      default: base = 9'd0;
    endcase
    if (leap && (mon >= 4'd3) && (mon <= 4'd13)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

### design/cdn_ctrl.sv
// Sequencing state machine for the calendar date normalizer.
module cdn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cdn_pkg::stat_t stat,
  output cdn_pkg::cmd_t  cmd
);
  import cdn_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_FOLD_MUL   = 8'b0000_0010,
    S_FOLD_APPLY = 8'b0000_0100,
    S_LEAP_MUL   = 8'b0000_1000,
    S_LEAP_APPLY = 8'b0001_0000,
    S_DAY_INIT   = 8'b0010_0000,
    S_STEP       = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_FOLD_MUL;
        end
      end
      S_FOLD_MUL: begin
        cmd.fold_mul = 1'b1;
        state_next = S_FOLD_APPLY;
      end
      S_FOLD_APPLY: begin
        cmd.fold_apply = 1'b1;
        state_next = S_LEAP_MUL;
      end
      S_LEAP_MUL: begin
        cmd.leap_mul = 1'b1;
        state_next = S_LEAP_APPLY;
      end
      S_LEAP_APPLY: begin
        cmd.leap_apply = 1'b1;
        state_next = S_DAY_INIT;
      end
      S_DAY_INIT: begin
        cmd.day_init = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (stat.in_range) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/cdn_datapath.sv
// Datapath of the calendar date normalizer: month fold, leap tracking, year stepping.
`include "calendar_date_normalizer_macros.svh"

module cdn_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cdn_pkg::cmd_t                         cmd,
  output cdn_pkg::stat_t                        stat,
  input  logic signed [cdn_pkg::YEAR_IN_W-1:0]  year_in,
  input  logic signed [cdn_pkg::MONTH_IN_W-1:0] month_in,
  input  logic signed [cdn_pkg::DAY_IN_W-1:0]   day_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cdn_pkg::YEAR_W-1:0]     year_out,
  output logic [cdn_pkg::MONTH_W-1:0]           month_out,
  output logic [cdn_pkg::MDAY_W-1:0]            day_of_month,
  output logic [cdn_pkg::YDAY_W-1:0]            day_of_year
);
  import cdn_pkg::*;

  logic signed [YEAR_W-1:0]     year;
  logic signed [MONTH_IN_W-1:0] month_raw;
  logic [MONTH_W-1:0]           mon;
  logic signed [DAY_IN_W-1:0]   day;
  logic [12:0]                  mabs;
  logic                         mneg;
  logic [25:0]                  mprod;
  logic [14:0]                  yoff;
  logic [30:0]                  yprod;
  logic [CYCLE_W-1:0]           r400;
  logic signed [YDAY_ACC_W-1:0] yday;

  // month fold
  logic signed [13:0] m0;
  logic [13:0]        m_abs_c;
  logic [9:0]         mq;
  logic [12:0]        mqx12;
  logic [3:0]         mrem;
  logic signed [10:0] yadd;
  logic [MONTH_W-1:0] mon_fold;

  assign m0      = {month_raw[MONTH_IN_W-1], month_raw} - 14'sd1;
  assign m_abs_c = m0[13] ? (14'd0 - m0) : m0;
  assign mq      = mprod[25:MON_SHIFT];
  assign mqx12   = {mq[9:0], 3'b000} + {1'b0, mq[9:0], 2'b00};
  assign mrem    = 4'(mabs - mqx12);

  always_comb begin
    if (!mneg) begin
      yadd     = $signed({1'b0, mq});
      mon_fold = mrem + 4'd1;
    end else if (mrem == 4'd0) begin
      yadd     = -$signed({1'b0, mq});
      mon_fold = 4'd1;
    end else begin
      yadd     = -$signed({1'b0, mq}) - 11'sd1;
      mon_fold = 4'd13 - mrem;
    end
  end

  // year position within the 400-year cycle
  logic signed [15:0] yoff_c;
  logic [6:0]         yq;
  logic [14:0]        yqx400;

  assign yoff_c = {year[YEAR_W-1], year} + YEAR_OFFSET;
  assign yq     = yprod[30:YEAR_SHIFT];
  assign yqx400 = 15'(yq * 15'(YEAR_CYCLE));

  // year stepping
  logic [8:0]         ndays;
  logic [8:0]         ndays_dec;
  logic [CYCLE_W-1:0] r_inc;
  logic [CYCLE_W-1:0] r_dec;
  logic               fwd;
  logic               back;
  logic               in_range;

  assign ndays     = ndays_of(r400);
  assign r_inc     = (r400 == 9'(YEAR_CYCLE - 1)) ? 9'd0 : r400 + 9'd1;
  assign r_dec     = (r400 == 9'd0) ? 9'(YEAR_CYCLE - 1) : r400 - 9'd1;
  assign ndays_dec = ndays_of(r_dec);
  assign fwd       = yday > $signed({8'b0, ndays});
  assign back      = yday < 17'sd1;
  assign in_range  = !fwd && !back;

  // month and day recovery
  logic               leap_f;
  logic [8:0]         yd9;
  logic [MONTH_W-1:0] mon_f;

  assign leap_f = leap_of(r400);
  assign yd9    = yday[8:0];

  always_comb begin
    mon_f = 4'd1;
    for (int k = 2; k <= MONTHS; k++) begin
      if (yd9 > cum_days(leap_f, 4'(k))) begin
        mon_f = mon_f + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year      <= {year_in[YEAR_IN_W-1], year_in};
      month_raw <= month_in;
      day       <= day_in;
    end
    if (cmd.fold_mul) begin
      mneg  <= m0[13];
      mabs  <= m_abs_c[12:0];
      mprod <= 26'(m_abs_c[12:0]) * 26'(MON_RECIP);
    end
    if (cmd.fold_apply) begin
      year <= year + {{(YEAR_W-11){yadd[10]}}, yadd};
      mon  <= mon_fold;
    end
    if (cmd.leap_mul) begin
      yoff  <= yoff_c[14:0];
      yprod <= 31'(yoff_c[14:0]) * 31'(YEAR_RECIP);
    end
    if (cmd.leap_apply) begin
      r400 <= 9'(yoff - yqx400);
    end
    if (cmd.day_init) begin
      yday <= $signed({8'b0, cum_days(leap_of(r400), mon)}) + {day[DAY_IN_W-1], day};
    end
    if (cmd.step) begin
      if (fwd) begin
        yday <= yday - $signed({8'b0, ndays});
        year <= year + 15'sd1;
        r400 <= r_inc;
      end else if (back) begin
        yday <= yday + $signed({8'b0, ndays_dec});
        year <= year - 15'sd1;
        r400 <= r_dec;
      end
    end
    if (cmd.finish) begin
      year_out     <= year;
      month_out    <= mon_f;
      day_of_month <= 5'(yd9 - cum_days(leap_f, mon_f));
      day_of_year  <= yd9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.in_range = in_range;
  assign stat.out_busy = out_valid && !out_ready;

  logic out_fields_ok;

  assign out_fields_ok = (month_out >= 4'd1) && (month_out <= 4'd12) &&
                         (day_of_month != 5'd0) && (day_of_year != 9'd0);

  `CDN_ASSERT_IMPLY(a_finish_in_range, clk, rst, cmd.finish, in_range && !stat.out_busy)
  `CDN_ASSERT_IMPLY(a_out_fields, clk, rst, out_valid, out_fields_ok)
  `CDN_ASSERT_NEXT(a_step_fwd, clk, rst, cmd.step && fwd, year == $past(year) + 15'sd1)

endmodule

### design/calendar_date_normalizer.sv
// Calendar date normalizer top level: a sequencer and its datapath.
//
// Input channel (in_valid/in_ready) takes a Gregorian date as year_in,
// month_in and day_in, any of which may lie outside its nominal range.
// Output channel (out_valid/out_ready) returns the normalized year_out,
// month_out, day_of_month and day_of_year, one transaction per input.
// One date is processed at a time. After the input transaction the block
// folds the month, places the year in its 400-year cycle and forms the
// day of year (S_FOLD_MUL, S_FOLD_APPLY, S_LEAP_MUL, S_LEAP_APPLY and
// S_DAY_INIT), then in S_STEP moves the year once for each year the day
// count spills over (up to about 90) until it is in range, then in
// S_FINISH recovers month and day; the next input can be taken once the
// result is registered. The year-stepping loop sets the rate.
// The result sits in an output register, so a new date is accepted while
// the previous result still waits; a stalled receiver only holds the
// sequencer once the next result is ready. Synchronous reset returns the
// sequencer to idle and drops out_valid; no other state is kept.
module calendar_date_normalizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cdn_pkg::YEAR_IN_W-1:0]  year_in,
  input  logic signed [cdn_pkg::MONTH_IN_W-1:0] month_in,
  input  logic signed [cdn_pkg::DAY_IN_W-1:0]   day_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cdn_pkg::YEAR_W-1:0]     year_out,
  output logic [cdn_pkg::MONTH_W-1:0]           month_out,
  output logic [cdn_pkg::MDAY_W-1:0]            day_of_month,
  output logic [cdn_pkg::YDAY_W-1:0]            day_of_year
);
  import cdn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cdn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdn_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .year_in      (year_in),
    .month_in     (month_in),
    .day_in       (day_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_of_month (day_of_month),
    .day_of_year  (day_of_year)
  );

endmodule
